### hw/rtl/atce_pkg.sv
// types and constants shared by the text code extractor modules
package atce_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       string_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0] char_kind;
    logic [6:0] code_high;
    logic [6:0] code_low;
    logic       string_done;
  } out_item_t;

  typedef enum logic [1:0] {
    KIND_JIS   = 2'd0,
    KIND_ASCII = 2'd1,
    KIND_NONE  = 2'd2
  } char_kind_e;

  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_DOLLAR   = 8'h24;
  localparam logic [7:0] CH_G0       = 8'h28;
  localparam logic [7:0] CH_G3       = 8'h2B;
  localparam logic [7:0] CH_LS0      = 8'h0F;
  localparam logic [7:0] CH_LS1      = 8'h0E;
  localparam logic [7:0] CH_SS2      = 8'h19;
  localparam logic [7:0] CH_SS3      = 8'h1D;
  localparam logic [7:0] CH_DEL      = 8'h7F;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] FIN_ALNUM   = 8'h4A;
  localparam logic [7:0] FIN_HIRA    = 8'h30;
  localparam logic [7:0] FIN_KATA    = 8'h31;
  localparam logic [7:0] FIN_KANJI_A = 8'h42;
  localparam logic [7:0] FIN_KANJI_B = 8'h39;
  localparam logic [7:0] FIN_KANJI_C = 8'h3A;
  localparam logic [7:0] FIN_KANJI_D = 8'h3B;
  localparam logic [6:0] ROW_HIRA    = 7'h24;
  localparam logic [6:0] ROW_KATA    = 7'h25;

endpackage

### hw/rtl/atce_in_reg.sv
// input register holding one byte item ahead of the decoder
module atce_in_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  atce_pkg::in_item_t in_item_i,
  output logic               vld_o,
  output atce_pkg::in_item_t item_o,
  input  logic               consume_i
);

  logic               valid_q, valid_d;
  atce_pkg::in_item_t item_q;
  logic               load;

  assign in_ready_o = !valid_q || consume_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (consume_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign vld_o  = valid_q;
  assign item_o = item_q;

endmodule

### hw/rtl/atce_decode.sv
// gl set tracking, escape parsing and character assembly for one byte
module atce_decode (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                vld_i,
  input  atce_pkg::in_item_t  item_i,
  input  logic                out_free_i,
  output logic                consume_o,
  output logic                res_vld_o,
  output atce_pkg::out_item_t res_o
);

  localparam logic [1:0] MODE_KANJI = 2'd0;
  localparam logic [1:0] MODE_ALNUM = 2'd1;
  localparam logic [1:0] MODE_HIRA  = 2'd2;
  localparam logic [1:0] MODE_KATA  = 2'd3;

  localparam logic [2:0] PH_IDLE        = 3'd0;
  localparam logic [2:0] PH_ESC         = 3'd1;
  localparam logic [2:0] PH_ESC_DOLLAR  = 3'd2;
  localparam logic [2:0] PH_ESC_NAMED   = 3'd3;
  localparam logic [2:0] PH_ESC_G0      = 3'd4;
  localparam logic [2:0] PH_ESC_SKIP    = 3'd5;
  localparam logic [2:0] PH_PAIR_SECOND = 3'd6;

  logic [1:0] mode_q, mode_d;
  logic [2:0] phase_q, phase_d;
  logic [6:0] held_q, held_d;

  logic       have;
  logic [1:0] kind;
  logic [6:0] hi, lo;
  logic [7:0] b;
  logic       last;
  logic       produce;

  assign b    = item_i.in_byte;
  assign last = item_i.string_end;

  always_comb begin
    mode_d  = mode_q;
    phase_d = PH_IDLE;
    held_d  = held_q;
    have    = 1'b0;
    kind    = atce_pkg::KIND_NONE;
    hi      = '0;
    lo      = '0;
    case (phase_q)
      PH_ESC: begin
        if (b == atce_pkg::CH_DOLLAR) begin
          phase_d = PH_ESC_DOLLAR;
        end else if (b == atce_pkg::CH_G0) begin
          phase_d = PH_ESC_G0;
        end else if (b > atce_pkg::CH_G0 && b <= atce_pkg::CH_G3) begin
          phase_d = PH_ESC_SKIP;
        end
      end
      PH_ESC_DOLLAR: begin
        if (b >= atce_pkg::CH_G0 && b <= atce_pkg::CH_G3) begin
          phase_d = PH_ESC_NAMED;
        end else begin
          mode_d = MODE_KANJI;
        end
      end
      PH_ESC_NAMED, PH_ESC_SKIP: begin
        phase_d = PH_IDLE;
      end
      PH_ESC_G0: begin
        case (b)
          atce_pkg::FIN_HIRA:    mode_d = MODE_HIRA;
          atce_pkg::FIN_KATA:    mode_d = MODE_KATA;
          atce_pkg::FIN_KANJI_A,
          atce_pkg::FIN_KANJI_B,
          atce_pkg::FIN_KANJI_C,
          atce_pkg::FIN_KANJI_D: mode_d = MODE_KANJI;
          default:               mode_d = MODE_ALNUM;
        endcase
      end
      PH_PAIR_SECOND: begin
        have   = 1'b1;
        kind   = atce_pkg::KIND_JIS;
        hi     = held_q;
        lo     = b[6:0];
        held_d = '0;
      end
      default: begin
        if (b == atce_pkg::CH_ESC) begin
          phase_d = PH_ESC;
        end else if (b == atce_pkg::CH_LS0) begin
          mode_d = MODE_KANJI;
        end else if (b == atce_pkg::CH_LS1) begin
          mode_d = MODE_ALNUM;
        end else if (b == atce_pkg::CH_SS2 || b == atce_pkg::CH_SS3) begin
          held_d  = (b == atce_pkg::CH_SS2) ? atce_pkg::ROW_HIRA : atce_pkg::ROW_KATA;
          phase_d = PH_PAIR_SECOND;
        end else if (b < atce_pkg::CH_SPACE) begin
          // other c0 control dropped
          phase_d = PH_IDLE;
        end else if (mode_q == MODE_KANJI) begin
          held_d  = b[6:0];
          phase_d = PH_PAIR_SECOND;
        end else if (mode_q == MODE_HIRA || mode_q == MODE_KATA) begin
          have = 1'b1;
          kind = atce_pkg::KIND_JIS;
          hi   = (mode_q == MODE_HIRA) ? atce_pkg::ROW_HIRA : atce_pkg::ROW_KATA;
          lo   = b[6:0];
        end else if (b < atce_pkg::CH_DEL) begin
          have = 1'b1;
          kind = atce_pkg::KIND_ASCII;
          lo   = b[6:0];
        end
      end
    endcase
    // end of string: back to reset state
    if (last) begin
      mode_d  = MODE_KANJI;
      phase_d = PH_IDLE;
      held_d  = '0;
    end
  end

  assign produce   = have || last;
  assign consume_o = vld_i && (out_free_i || !produce);
  assign res_vld_o = consume_o && produce;

  always_comb begin
    res_o.char_kind   = kind;
    res_o.code_high   = hi;
    res_o.code_low    = lo;
    res_o.string_done = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_KANJI;
      phase_q <= PH_IDLE;
      held_q  <= '0;
    end else if (consume_o) begin
      mode_q  <= mode_d;
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

  a_end_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    consume_o && last |=> phase_q == PH_IDLE && mode_q == MODE_KANJI && held_q == '0)
    else $error("state not cleared after end of string");

  a_end_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    consume_o && last |-> res_vld_o && res_o.string_done)
    else $error("end of string without result");

  a_phase_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= PH_PAIR_SECOND)
    else $error("parse phase out of range");

  a_none_is_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_o && res_o.char_kind == atce_pkg::KIND_NONE |->
      res_o.string_done && res_o.code_high == '0 && res_o.code_low == '0)
    else $error("end marker carries a character");

endmodule

### hw/rtl/atce_out_reg.sv
// result register towards the output channel
module atce_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_i,
  input  atce_pkg::out_item_t res_i,
  output logic                free_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output atce_pkg::out_item_t out_item_o
);

  logic                valid_q, valid_d;
  atce_pkg::out_item_t item_q;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (wr_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      item_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_i |-> !valid_q || out_ready_i)
    else $error("result written over an item not yet taken");

endmodule

### hw/rtl/arib_text_code_extractor.sv
// top level of the arib 8-bit text code extractor
// Takes one byte item per cycle while the output does not stall and gives zero or one
// result per byte: a JIS X 0208 row/cell pair, a printable ASCII code, or an end marker
// when a string's last byte has no character; string_done is set on that byte's result.
// Throughput is one byte per clock if unstalled; the GL set and escape parse state are
// updated once per byte. Bytes pass the input register, then results the result register.
// Bytes with no result (escape sequences, controls, the first byte of a pair) move on even
// while the output stalls; all state returns to the kanji set after a string's last byte.
module arib_text_code_extractor (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  atce_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output atce_pkg::out_item_t out_item_o
);

  logic                dec_vld;
  atce_pkg::in_item_t  dec_item;
  logic                consume;
  logic                res_vld;
  atce_pkg::out_item_t res;
  logic                out_free;

  atce_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .vld_o      (dec_vld),
    .item_o     (dec_item),
    .consume_i  (consume)
  );

  atce_decode u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .vld_i      (dec_vld),
    .item_i     (dec_item),
    .out_free_i (out_free),
    .consume_o  (consume),
    .res_vld_o  (res_vld),
    .res_o      (res)
  );

  atce_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (res_vld),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
